>>> sv/bmfa_pkg.sv
`default_nettype none
package bmfa_pkg;

   localparam int ByteW    = 8;
   localparam int ExpW     = 3;
   localparam int MantW    = 4;
   localparam int MagW     = 11;
   localparam int MfValW   = MagW + 1;
   localparam int SumW     = MfValW + 1;
   localparam int AbsW     = SumW - 1;
   localparam int PosW     = 4;

   localparam logic [ExpW-1:0] ExpMax = 3'd7;
   localparam logic [PosW-1:0] ExpBias = 4'd3;
   localparam logic [PosW-1:0] PosTop  = 4'(AbsW - 1);
   localparam logic [PosW-1:0] PosSat  = 4'd10;

   localparam logic OpIntAdd = 1'b0;
   localparam logic OpMfAdd  = 1'b1;

   typedef logic [ByteW-1:0]         byte_type;
   typedef logic signed [MfValW-1:0] mf_value_type;

endpackage
`default_nettype wire

>>> sv/bmfa_mf_decode.sv
`default_nettype none
module bmfa_mf_decode (
   input  var bmfa_pkg::byte_type     mf_byte,
   output var bmfa_pkg::mf_value_type mf_value
);
   import bmfa_pkg::*;

   logic [ExpW-1:0]  exp_bits;
   logic [MantW-1:0] mant_bits;
   logic [MagW-1:0]  mag;

   always_comb begin
      exp_bits  = mf_byte[ByteW-2 -: ExpW];
      mant_bits = mf_byte[MantW-1:0];
      if (exp_bits == '0) begin
         mag = MagW'({1'b1, mant_bits});
      end else begin
         mag = MagW'({1'b1, mant_bits}) << (exp_bits - 3'd1);
      end
      if (exp_bits == '0 && mant_bits == '0) begin
         mf_value = '0;
      end else if (mf_byte[ByteW-1]) begin
         mf_value = -$signed({1'b0, mag});
      end else begin
         mf_value = $signed({1'b0, mag});
      end
   end

endmodule
`default_nettype wire

>>> sv/byte_and_minifloat_adder_core.sv
`default_nettype none
// Byte and minifloat adder core.
// Input channel req_: req_opcode (0 integer add mod 256, 1 minifloat add),
// req_operand_a and req_operand_b, with req_valid / req_ready.
// Result channel rsp_: rsp_result with rsp_valid / rsp_ready.
// Every accepted word gives exactly one result word, in order.
// Four register stages: operand decode, signed add and magnitude,
// leading-one search, normalize and pack into the output register.
// An accepted word passes these stages in order to rsp_valid; one word per cycle
// is sustained while rsp_ready is high.
// Each stage advances when it is empty or the stage after it advances,
// so bubbles collapse and a word is taken while a result still waits.
// When the receiver holds rsp_ready low the pipeline fills, then
// req_ready drops; no word is lost or repeated.
// Synchronous active-high reset empties all stages; payload registers
// are not reset.
module byte_and_minifloat_adder_core (
   input  var logic               clock,
   input  var logic               reset,
   input  var logic               req_valid,
   output var logic               req_ready,
   input  var logic               req_opcode,
   input  var bmfa_pkg::byte_type req_operand_a,
   input  var bmfa_pkg::byte_type req_operand_b,
   output var logic               rsp_valid,
   input  var logic               rsp_ready,
   output var bmfa_pkg::byte_type rsp_result
);
   import bmfa_pkg::*;

   logic en1, en2, en3, en4;

   mf_value_type va_dec, vb_dec;

   logic         v1_ff, op1_ff;
   byte_type     int1_ff;
   mf_value_type va1_ff, vb1_ff;

   logic                 v2_ff, op2_ff, neg2_ff;
   byte_type             int2_ff;
   logic [AbsW-1:0]      mag2_ff;
   logic signed [SumW-1:0] sum_in;
   logic [SumW-1:0]      abs_in;

   logic            v3_ff, op3_ff, neg3_ff, zero3_ff;
   byte_type        int3_ff;
   logic [AbsW-1:0] mag3_ff;
   logic [PosW-1:0] pos3_ff, pos_in;

   logic            rsp_valid_ff;
   byte_type        rsp_result_ff, result_in;
   logic [AbsW-1:0] norm;
   logic [ExpW-1:0] bexp;

   bmfa_mf_decode u_dec_a (.mf_byte(req_operand_a), .mf_value(va_dec));
   bmfa_mf_decode u_dec_b (.mf_byte(req_operand_b), .mf_value(vb_dec));

   assign en4 = !rsp_valid_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready  = en1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   always_comb begin
      sum_in = SumW'(va1_ff) + SumW'(vb1_ff);
      abs_in = sum_in[SumW-1] ? SumW'(-sum_in) : SumW'(sum_in);
   end

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < AbsW; i++) begin
         if (mag2_ff[i]) pos_in = PosW'(i);
      end
   end

   always_comb begin
      norm = AbsW'(mag3_ff << (PosTop - pos3_ff));
      if (pos3_ff < ExpBias) begin
         bexp = '0;
      end else if (pos3_ff >= PosSat) begin
         bexp = ExpMax;
      end else begin
         bexp = ExpW'(pos3_ff - ExpBias);
      end
      if (op3_ff == OpIntAdd) begin
         result_in = int3_ff;
      end else if (zero3_ff) begin
         result_in = '0;
      end else begin
         result_in = {neg3_ff, bexp, norm[AbsW-2 -: MantW]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff  <= req_opcode;
         int1_ff <= ByteW'(req_operand_a + req_operand_b);
         va1_ff  <= va_dec;
         vb1_ff  <= vb_dec;
      end
      if (en2) begin
         op2_ff  <= op1_ff;
         int2_ff <= int1_ff;
         neg2_ff <= sum_in[SumW-1];
         mag2_ff <= abs_in[AbsW-1:0];
      end
      if (en3) begin
         op3_ff   <= op2_ff;
         int3_ff  <= int2_ff;
         neg3_ff  <= neg2_ff;
         zero3_ff <= (mag2_ff == '0);
         mag3_ff  <= mag2_ff;
         pos3_ff  <= pos_in;
      end
      if (en4) begin
         rsp_result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire
